// ===== rtl/core/lss_pkg.sv =====
// Package for the literal string search block: sizes, command and
// register codes, payload structs and the character fold function.
// Depends on nothing; used by literal_string_search.
package lss_pkg;

  localparam int PAT_MAX   = 32;
  localparam int CHAR_BITS = 8;
  localparam int PAT_IDX_W = (PAT_MAX > 1) ? $clog2(PAT_MAX) : 1;
  localparam int FILL_W    = $clog2(PAT_MAX + 1);
  localparam int COUNT_W   = 16;

  typedef logic [CHAR_BITS-1:0] char_t;

  typedef enum logic [1:0] {
    CMD_LOAD    = 2'd0,
    CMD_TEXT    = 2'd1,
    CMD_RESTART = 2'd2
  } cmd_t;

  typedef enum logic [1:0] {
    CFG_CASE_FOLD       = 2'd0,
    CFG_SEARCH_BACKWARD = 2'd1,
    CFG_PATTERN_LENGTH  = 2'd2
  } cfg_reg_t;

  typedef struct packed {
    logic [1:0] command;
    logic [7:0] char_value;
    logic [4:0] pattern_index;
    logic       end_of_text;
  } in_item_t;

  typedef struct packed {
    logic               found;
    logic               not_found;
    logic [COUNT_W-1:0] match_offset;
  } out_item_t;

  function automatic char_t fold_char(input logic fold, input char_t c);
    char_t res;
    res = c;
    if (fold && c >= char_t'(8'h61) && c <= char_t'(8'h7A)) begin
      res = c - char_t'(8'h20);
    end
    return res;
  endfunction

endpackage

// ===== rtl/core/literal_string_search.sv =====
// Literal string search top level: input register, parallel window
// compare and result register. Depends on lss_pkg.
//
// Usage:
//   cfg channel  : cfg_index selects case_fold (0), search_backward (1) or
//                  pattern_length (2); cfg_data carries the value. Always ready.
//                  Write only while no item is in flight.
//   in channel   : in_data carries command, char_value, pattern_index and
//                  end_of_text. Load commands fill the pattern, text commands
//                  shift the text window until the search is done, restart
//                  clears fill, count and the done flag but keeps the window.
//   out channel  : one result per input item: found, not_found, match_offset.
// Timing:
//   Results pass through the input register, then the result register.
//   One item per cycle sustained while out_ready stays high; all PAT_MAX
//   window comparators work in parallel in the single compare stage.
//   When out_ready is low the held result blocks the compare stage, and
//   in_ready drops once the input register is also occupied.
// Reset:
//   rst_n (synchronous) empties both stages and clears the registers to
//   case_fold 0, search_backward 0, pattern_length 1 and the search state.
//   The pattern store is undefined until loaded.
module literal_string_search (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_valid,
  output logic                  in_ready,
  input  lss_pkg::in_item_t     in_data,
  output logic                  out_valid,
  input  logic                  out_ready,
  output lss_pkg::out_item_t    out_data,
  input  logic                  cfg_valid,
  output logic                  cfg_ready,
  input  logic [1:0]            cfg_index,
  input  logic [5:0]            cfg_data
);

  localparam int PM  = lss_pkg::PAT_MAX;
  localparam int PIW = lss_pkg::PAT_IDX_W;
  localparam int FW  = lss_pkg::FILL_W;
  localparam int CW  = lss_pkg::COUNT_W;

  logic                 case_fold_r;
  logic                 search_backward_r;
  logic [5:0]           pattern_length_r;

  logic                 s1_valid_r;
  lss_pkg::in_item_t    s1_r;
  logic                 s1_adv;

  lss_pkg::char_t       pat_r   [PM];
  lss_pkg::char_t       win_r   [PM];
  lss_pkg::char_t       win_nxt [PM];
  logic [FW-1:0]        fill_r;
  logic [FW-1:0]        fill_nxt;
  logic [CW-1:0]        count_r;
  logic [CW-1:0]        count_nxt;
  logic                 done_r;
  logic                 done_nxt;

  logic                 out_valid_r;
  lss_pkg::out_item_t   out_r;
  lss_pkg::out_item_t   out_nxt;

  lss_pkg::char_t       ch;
  logic [FW-1:0]        len_used;
  logic [FW-1:0]        pidx;
  logic                 all_eq;
  logic                 is_text;

  assign cfg_ready = 1'b1;
  assign s1_adv    = !out_valid_r || out_ready;
  assign in_ready  = !s1_valid_r || s1_adv;
  assign out_valid = out_valid_r;
  assign out_data  = out_r;
  assign ch        = lss_pkg::char_t'(s1_r.char_value);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      case_fold_r       <= 1'b0;
      search_backward_r <= 1'b0;
      pattern_length_r  <= 6'd1;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        lss_pkg::CFG_CASE_FOLD:       case_fold_r       <= cfg_data[0];
        lss_pkg::CFG_SEARCH_BACKWARD: search_backward_r <= cfg_data[0];
        lss_pkg::CFG_PATTERN_LENGTH:  pattern_length_r  <= cfg_data;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (in_ready) begin
      s1_valid_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ready && in_valid) begin
      s1_r <= in_data;
    end
  end

  always_comb begin
    if (pattern_length_r == 6'd0) begin
      len_used = FW'(1);
    end else if (int'(pattern_length_r) > PM) begin
      len_used = FW'(PM);
    end else begin
      len_used = FW'(pattern_length_r);
    end
  end

  always_comb begin
    is_text   = (s1_r.command == lss_pkg::CMD_TEXT) && !done_r;
    fill_nxt  = fill_r;
    count_nxt = count_r;
    done_nxt  = done_r;
    for (int w = 0; w < PM; w++) begin
      win_nxt[w] = win_r[w];
    end
    if (s1_r.command == lss_pkg::CMD_RESTART) begin
      fill_nxt  = '0;
      count_nxt = '0;
      done_nxt  = 1'b0;
    end else if (is_text) begin
      win_nxt[0] = ch;
      for (int w = 1; w < PM; w++) begin
        win_nxt[w] = win_r[w-1];
      end
      if (fill_r < FW'(PM)) begin
        fill_nxt = fill_r + FW'(1);
      end
      if (count_r != {CW{1'b1}}) begin
        count_nxt = count_r + CW'(1);
      end
    end

    all_eq = (fill_nxt >= len_used);
    pidx   = '0;
    for (int w = 0; w < PM; w++) begin
      if (FW'(w) < len_used) begin
        pidx = search_backward_r ? FW'(w) : (len_used - FW'(1) - FW'(w));
        if (lss_pkg::fold_char(case_fold_r, win_nxt[w]) !=
            lss_pkg::fold_char(case_fold_r, pat_r[pidx[PIW-1:0]])) begin
          all_eq = 1'b0;
        end
      end
    end

    out_nxt.found        = 1'b0;
    out_nxt.not_found    = 1'b0;
    out_nxt.match_offset = count_nxt;
    if (is_text) begin
      if (all_eq) begin
        out_nxt.found = 1'b1;
        done_nxt      = 1'b1;
      end else if (s1_r.end_of_text) begin
        out_nxt.not_found = 1'b1;
        done_nxt          = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fill_r      <= '0;
      count_r     <= '0;
      done_r      <= 1'b0;
      out_valid_r <= 1'b0;
    end else if (s1_adv) begin
      out_valid_r <= s1_valid_r;
      if (s1_valid_r) begin
        fill_r  <= fill_nxt;
        count_r <= count_nxt;
        done_r  <= done_nxt;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (s1_adv && s1_valid_r) begin
      out_r <= out_nxt;
      for (int w = 0; w < PM; w++) begin
        win_r[w] <= win_nxt[w];
      end
      if (s1_r.command == lss_pkg::CMD_LOAD && int'(s1_r.pattern_index) < PM) begin
        pat_r[PIW'(s1_r.pattern_index)] <= ch;
      end
    end
  end

  a_found_excl: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> !(out_data.found && out_data.not_found))
    else $error("found and not_found both set");

  a_done_after_hit: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && (out_data.found || out_data.not_found)) |-> done_r)
    else $error("search result shown without done flag");

  a_count_fill: assert property (@(posedge clk) disable iff (!rst_n)
    (fill_r <= FW'(PM)) && (CW'(fill_r) <= count_r))
    else $error("window fill out of step with byte count");

  a_stall_cause: assert property (@(posedge clk) disable iff (!rst_n)
    !in_ready |-> (s1_valid_r && out_valid && !out_ready))
    else $error("input stalled without a downstream stall");

endmodule

// ===== tb/sv/tb_literal_string_search.sv =====
`timescale 1ns / 100ps
// Self-checking testbench for literal_string_search: directed table, then random
// searches under several register settings, checked against the table or a built-in predictor.
// Depends on lss_pkg and the literal_string_search RTL.
module tb_literal_string_search;
  import lss_pkg::*;

  localparam logic [1:0] CMD_UNKNOWN = 2'd3;
  localparam logic [7:0] LC_A        = 8'h61;
  localparam logic [7:0] LC_Z        = 8'h7A;
  localparam logic [7:0] CASE_GAP    = 8'h20;
  localparam logic [7:0] NEWLINE     = 8'h0A;
  localparam int         STALL_LIMIT = 2000;
  localparam int         PHASES      = 9;
  localparam int         PHASE_ITEMS = 56;

  typedef struct {
    in_item_t  it;
    bit        typed;
    out_item_t res;
  } row_t;

  logic      clk;
  logic      rst_n;
  logic      in_valid;
  logic      in_ready;
  in_item_t  in_data;
  logic      out_valid;
  logic      out_ready;
  out_item_t out_data;
  logic      cfg_valid;
  logic      cfg_ready;
  logic [1:0] cfg_index;
  logic [5:0] cfg_data;

  logic [7:0]  pat_mem [PAT_MAX];
  logic [7:0]  win_mem [PAT_MAX];
  int          win_fill;
  logic [15:0] text_count;
  bit          search_over;
  bit          fold_on;
  bit          backward_on;
  logic [5:0]  len_reg;

  out_item_t pending_results[$];
  row_t      dir_rows[$];
  int        err_cnt;
  int        items_sent;
  int        src_gap_pct;
  int        snk_gap_pct;
  int        hold_req;
  int        hold_left;
  int        idle_cycles;

  int         ph_fold [PHASES] = '{0, 1, 0, 1, 1, 0, 0, 1, 0};
  int         ph_back [PHASES] = '{0, 0, 1, 1, 0, 1, 0, 1, 0};
  int         ph_len  [PHASES] = '{4, 1, 32, 3, 0, 63, 32, 8, 2};
  logic [7:0] char_pool [9] = '{8'h41, 8'h42, 8'h61, 8'h62, 8'h0A, 8'h7A, 8'h7B, 8'h60,
                                8'h40};

  literal_string_search uut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  initial clk = 1'b0;
  always #6 clk = ~clk;

  function automatic logic [7:0] upcase(logic [7:0] c);
    return (fold_on && c >= LC_A && c <= LC_Z) ? c - CASE_GAP : c;
  endfunction

  function automatic int used_len();
    int n;
    n = int'(len_reg);
    if (n == 0) n = 1;
    if (n > PAT_MAX) n = PAT_MAX;
    return n;
  endfunction

  function automatic out_item_t search_step(in_item_t it);
    out_item_t r;
    int        ulen;
    int        i;
    bit        hit;
    r = '0;
    case (it.command)
      CMD_LOAD: pat_mem[it.pattern_index] = it.char_value;
      CMD_RESTART: begin
        foreach (win_mem[j]) win_mem[j] = '0;
        win_fill    = 0;
        text_count  = '0;
        search_over = 1'b0;
      end
      CMD_TEXT: begin
        if (!search_over) begin
          for (i = PAT_MAX - 1; i > 0; i--) win_mem[i] = win_mem[i-1];
          win_mem[0] = it.char_value;
          if (win_fill < PAT_MAX) win_fill++;
          if (text_count != 16'hFFFF) text_count++;
          ulen = used_len();
          hit  = (win_fill >= ulen);
          for (i = 0; i < ulen; i++) begin
            if (upcase(win_mem[backward_on ? i : ulen - 1 - i]) != upcase(pat_mem[i])) begin
              hit = 1'b0;
            end
          end
          if (hit) begin
            r.found     = 1'b1;
            search_over = 1'b1;
          end else if (it.end_of_text) begin
            r.not_found = 1'b1;
            search_over = 1'b1;
          end
        end
      end
      default: ;
    endcase
    r.match_offset = text_count;
    return r;
  endfunction

  function automatic in_item_t mk(logic [1:0] cmd, logic [7:0] ch, logic [4:0] idx,
                                  logic eot);
    in_item_t it;
    it.command       = cmd;
    it.char_value    = ch;
    it.pattern_index = idx;
    it.end_of_text   = eot;
    return it;
  endfunction

  function automatic logic [7:0] pick_char();
    int k;
    k = $urandom_range(9);
    return (k == 9) ? 8'($urandom_range(255)) : char_pool[k];
  endfunction

  function automatic in_item_t noise_item();
    return mk(2'($urandom_range(3)), 8'($urandom_range(255)), 5'($urandom_range(31)),
              1'($urandom_range(1)));
  endfunction

  task automatic add_row(in_item_t it, bit typed, logic f, logic nf, logic [15:0] off);
    row_t r;
    r.it                 = it;
    r.typed              = typed;
    r.res.found          = f;
    r.res.not_found      = nf;
    r.res.match_offset   = off;
    dir_rows.push_back(r);
  endtask

  task automatic push_item(in_item_t it, bit typed, out_item_t res);
    out_item_t pred;
    while ($urandom_range(99) < src_gap_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= it;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    pred = search_step(it);
    pending_results.push_back(typed ? res : pred);
    items_sent++;
  endtask

  task automatic send(in_item_t it);
    push_item(it, 1'b0, '0);
  endtask

  task automatic drain();
    in_valid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (3) @(posedge clk);
  endtask

  task automatic write_reg(cfg_reg_t idx, logic [5:0] val);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    case (idx)
      CFG_CASE_FOLD:       fold_on     = val[0];
      CFG_SEARCH_BACKWARD: backward_on = val[0];
      CFG_PATTERN_LENGTH:  len_reg     = val;
      default: ;
    endcase
  endtask

  task automatic set_regs(int f, int b, int l);
    write_reg(CFG_CASE_FOLD, 6'(f));
    write_reg(CFG_SEARCH_BACKWARD, 6'(b));
    write_reg(CFG_PATTERN_LENGTH, 6'(l));
    cfg_valid <= 1'b0;
  endtask

  task automatic run_search();
    logic [7:0] txt[$];
    logic [7:0] c;
    int         ulen;
    int         k;
    ulen = used_len();
    send(mk(CMD_RESTART, 8'($urandom_range(255)), 5'($urandom_range(31)),
            1'($urandom_range(1))));
    if ($urandom_range(1)) begin
      for (k = 0; k < ulen; k++) send(mk(CMD_LOAD, pick_char(), 5'(k), 1'($urandom_range(1))));
    end
    repeat ($urandom_range(12)) txt.push_back(pick_char());
    if ($urandom_range(9) < 7) begin
      for (k = 0; k < ulen; k++) begin
        c = pat_mem[backward_on ? ulen - 1 - k : k];
        if ((c | CASE_GAP) >= LC_A && (c | CASE_GAP) <= LC_Z && $urandom_range(2) == 0) begin
          c = c ^ CASE_GAP;
        end
        txt.push_back(c);
      end
    end
    repeat ($urandom_range(4)) txt.push_back(pick_char());
    if (txt.size() == 0) txt.push_back(NEWLINE);
    for (k = 0; k < txt.size(); k++) begin
      if ($urandom_range(11) == 0) send(noise_item());
      send(mk(CMD_TEXT, txt[k], 5'($urandom_range(31)), k == txt.size() - 1));
    end
    if ($urandom_range(4) == 0) begin
      repeat (2) send(mk(CMD_TEXT, pick_char(), 5'($urandom_range(31)), 1'($urandom_range(1))));
    end
  endtask

  always @(posedge clk) begin
    out_item_t e;
    if (rst_n && out_valid && out_ready) begin
      if (pending_results.size() == 0) begin
        $display("%0t: unexpected result found=%0d not_found=%0d match_offset=%0d", $time,
                 out_data.found, out_data.not_found, out_data.match_offset);
        err_cnt++;
      end else begin
        e = pending_results.pop_front();
        if (out_data.found !== e.found) begin
          $display("%0t: found mismatch exp %0d got %0d", $time, e.found, out_data.found);
          err_cnt++;
        end
        if (out_data.not_found !== e.not_found) begin
          $display("%0t: not_found mismatch exp %0d got %0d", $time, e.not_found,
                   out_data.not_found);
          err_cnt++;
        end
        if (out_data.match_offset !== e.match_offset) begin
          $display("%0t: match_offset mismatch exp %0d got %0d", $time, e.match_offset,
                   out_data.match_offset);
          err_cnt++;
        end
      end
    end
    if (hold_req > 0) begin
      hold_left = hold_req;
      hold_req  = 0;
    end
    if (hold_left > 0) begin
      hold_left--;
      out_ready <= 1'b0;
    end else begin
      out_ready <= ($urandom_range(99) >= snk_gap_pct);
    end
  end

  always @(posedge clk) begin
    if ((in_valid && in_ready) || (out_valid && out_ready) || (cfg_valid && cfg_ready)) begin
      idle_cycles = 0;
    end else begin
      idle_cycles++;
    end
    if (idle_cycles >= STALL_LIMIT) begin
      $display("[literal_string_search] ERROR");
      $finish;
    end
  end

  initial begin
    int p;
    int k;
    int start_cnt;
    rst_n       <= 1'b0;
    in_valid    <= 1'b0;
    in_data     <= '0;
    out_ready   <= 1'b0;
    cfg_valid   <= 1'b0;
    cfg_index   <= '0;
    cfg_data    <= '0;
    err_cnt     = 0;
    items_sent  = 0;
    hold_req    = 0;
    hold_left   = 0;
    idle_cycles = 0;
    src_gap_pct = 19;
    snk_gap_pct = 72;
    fold_on     = 1'b0;
    backward_on = 1'b0;
    len_reg     = 6'd1;
    foreach (pat_mem[j]) pat_mem[j] = '0;
    void'(search_step(mk(CMD_RESTART, '0, '0, 1'b0)));

    add_row(mk(CMD_RESTART, 8'h00, 5'd0, 1'b0), 1, 0, 0, 0);
    add_row(mk(CMD_UNKNOWN, 8'hFF, 5'd31, 1'b1), 1, 0, 0, 0);
    add_row(mk(CMD_LOAD, 8'h41, 5'd0, 1'b0), 1, 0, 0, 0);
    add_row(mk(CMD_TEXT, 8'h42, 5'd0, 1'b0), 1, 0, 0, 1);
    add_row(mk(CMD_TEXT, 8'h41, 5'd0, 1'b0), 1, 1, 0, 2);
    add_row(mk(CMD_TEXT, 8'h41, 5'd31, 1'b1), 1, 0, 0, 2);
    add_row(mk(CMD_UNKNOWN, 8'h00, 5'd0, 1'b0), 1, 0, 0, 2);
    add_row(mk(CMD_RESTART, 8'hFF, 5'd31, 1'b1), 1, 0, 0, 0);
    add_row(mk(CMD_TEXT, 8'h61, 5'd0, 1'b1), 1, 0, 1, 1);
    add_row(mk(CMD_RESTART, 8'h00, 5'd0, 1'b0), 1, 0, 0, 0);
    add_row(mk(CMD_TEXT, 8'h41, 5'd0, 1'b1), 1, 1, 0, 1);
    add_row(mk(CMD_LOAD, 8'hFF, 5'd31, 1'b1), 1, 0, 0, 1);
    add_row(mk(CMD_LOAD, 8'h00, 5'd0, 1'b0), 1, 0, 0, 1);
    add_row(mk(CMD_RESTART, 8'h00, 5'd0, 1'b0), 1, 0, 0, 0);
    add_row(mk(CMD_TEXT, 8'hFF, 5'd31, 1'b0), 1, 0, 0, 1);
    add_row(mk(CMD_TEXT, 8'h00, 5'd0, 1'b1), 1, 1, 0, 2);
    add_row(mk(CMD_RESTART, 8'h00, 5'd0, 1'b0), 0, 0, 0, 0);
    add_row(mk(CMD_LOAD, 8'h7A, 5'd0, 1'b0), 0, 0, 0, 0);
    add_row(mk(CMD_TEXT, 8'h5A, 5'd0, 1'b0), 0, 0, 0, 0);
    add_row(mk(CMD_TEXT, 8'h7A, 5'd0, 1'b0), 0, 0, 0, 0);
    add_row(mk(CMD_RESTART, 8'h00, 5'd0, 1'b0), 0, 0, 0, 0);
    add_row(mk(CMD_TEXT, NEWLINE, 5'd0, 1'b1), 0, 0, 0, 0);

    repeat (7) @(posedge clk);
    rst_n <= 1'b1;

    foreach (dir_rows[j]) push_item(dir_rows[j].it, dir_rows[j].typed, dir_rows[j].res);
    drain();

    for (k = 0; k < PAT_MAX; k++) send(mk(CMD_LOAD, pick_char(), 5'(k), 1'($urandom_range(1))));
    drain();

    for (p = 0; p < PHASES; p++) begin
      if (p == 3) begin
        src_gap_pct = 72;
        snk_gap_pct = 19;
      end else if (p == 6) begin
        src_gap_pct = 0;
        snk_gap_pct = 0;
      end
      set_regs(ph_fold[p], ph_back[p], ph_len[p]);
      if (p == 1 || p == 7) hold_req = 80;
      start_cnt = items_sent;
      while (items_sent - start_cnt < PHASE_ITEMS) run_search();
      drain();
    end

    repeat (8) @(posedge clk);
    if (err_cnt == 0) begin
      $display("[literal_string_search] OK");
    end else begin
      $display("[literal_string_search] ERROR");
    end
    $finish;
  end

endmodule

// ===== literal_string_search.f =====
rtl/core/lss_pkg.sv
rtl/core/literal_string_search.sv
tb/sv/tb_literal_string_search.sv
